// ----- hdl/ecb_pkg.sv -----
// Types and constants shared by the edge coverage recorder.
package ecb_pkg;

   localparam int HDR_LSB = 22;
   localparam int HDR_W   = 5;

   localparam logic [HDR_W-1:0] HDR_BRANCH    = 5'h18;
   localparam logic [HDR_W-1:0] HDR_CALL_COND = 5'h1a;
   localparam logic [HDR_W-1:0] HDR_CALL_ABS  = 5'h1c;

   typedef enum logic [1:0] {
      CMD_STEP  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_START = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [53:0] instr;
      logic [31:0] pc;
      logic [15:0] index;
   } req_type;

   typedef struct packed {
      logic [7:0]  count;
      logic [15:0] map_key;
      logic        traced;
   } rsp_type;

endpackage

// ----- hdl/ecb_ifs.sv -----
// Valid/ready channel interfaces for command items and result items.
interface ecb_req_if;
   logic             valid;
   logic             ready;
   ecb_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ecb_rsp_if;
   logic             valid;
   logic             ready;
   ecb_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/edge_coverage_bitmap.sv -----
// Edge coverage recorder: hit-count map in one synchronous memory.
//
// Channels: req_ch carries command items (step, read-and-clear, start run),
// rsp_ch returns exactly one result item per command, in order.
// Each item is accepted in IDLE and its map entry is read from the memory at
// the accept edge; EXEC then modifies, writes back and loads the output
// register, once that register is free. An item passes through the memory
// read and then the update in EXEC, and req_ready is low in EXEC, so a new
// item is accepted only after the previous one has left EXEC.
// rsp_valid rises at the edge on which EXEC loads the output register, which
// then holds the result while rsp_ready is low; one further item may be
// accepted meanwhile and waits in EXEC until the register frees.
// Reset starts a clearing pass that zeroes all 2**MAP_BITS map entries
// (65536 at the default), one entry per cycle; req_ready stays low until it
// ends. The previous location register clears at once.
module edge_coverage_bitmap #(
   parameter int MAP_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ecb_req_if.sink    req_ch,
   ecb_rsp_if.source  rsp_ch
);
   import ecb_pkg::*;

   localparam int MAP_ENTRIES = 1 << MAP_BITS;

   logic [7:0] hit_map [MAP_ENTRIES];

   state_type           state_ff, state_in;
   logic [MAP_BITS-1:0] clr_ff, clr_in;
   logic [MAP_BITS-1:0] prev_ff, prev_in;
   logic [MAP_BITS-1:0] key_ff, key_in;
   cmd_type             op_ff;
   logic                branch_ff, branch_in;
   logic [7:0]          rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                out_load;
   logic                mem_we;
   logic [MAP_BITS-1:0] mem_waddr;
   logic [7:0]          mem_wdata;
   logic [31:0]         scr;
   logic [HDR_W-1:0]    hdr;

   assign accept = req_ch.valid && req_ch.ready;
   assign scr    = {req_ch.data.pc[28:0], 3'b000} ^ {3'b000, req_ch.data.pc[31:3]};
   assign hdr    = req_ch.data.instr[HDR_LSB +: HDR_W];

   always_comb begin
      branch_in = (hdr == HDR_BRANCH) || (hdr == HDR_CALL_COND) || (hdr == HDR_CALL_ABS);
      prev_in   = prev_ff;
      key_in    = '0;
      case (cmd_type'(req_ch.data.cmd))
         CMD_STEP: begin
            key_in = scr[MAP_BITS-1:0] ^ prev_ff;
            if (branch_in) begin
               prev_in = scr[MAP_BITS:1];
            end
         end
         CMD_READ: begin
            key_in = MAP_BITS'(req_ch.data.index);
         end
         CMD_START: begin
            prev_in = '0;
         end
         default: begin
            key_in = '0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      req_ch.ready   = 1'b0;
      out_load       = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = key_ff;
      mem_wdata      = '0;
      rsp_data_in    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + MAP_BITS'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               case (op_ff)
                  CMD_STEP: begin
                     if (branch_ff) begin
                        mem_we      = 1'b1;
                        mem_wdata   = rd_data_ff + 8'd1;
                        rsp_data_in = '{count: rd_data_ff + 8'd1,
                                        map_key: 16'(key_ff), traced: 1'b1};
                     end
                  end
                  CMD_READ: begin
                     mem_we      = 1'b1;
                     rsp_data_in = '{count: rd_data_ff, map_key: 16'(key_ff),
                                     traced: 1'b0};
                  end
                  CMD_START: begin
                     mem_we      = 1'b1;
                     mem_wdata   = 8'd1;
                     rsp_data_in = '{count: 8'd1, map_key: 16'd0, traced: 1'b0};
                  end
                  default: begin
                     rsp_data_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prev_ff <= prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff    <= key_in;
         op_ff     <= cmd_type'(req_ch.data.cmd);
         branch_ff <= branch_in;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hit_map[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= hit_map[key_in];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ----- hdl/ecb_checker.sv -----
// Port-level assertions for the edge coverage recorder, bound to its top level.
module ecb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ecb_pkg::rsp_type rsp_data
);
   import ecb_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("item accepted during clearing pass");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("item accepted in update cycle");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire, 2))
      else $error("result without accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind edge_coverage_bitmap ecb_checker u_ecb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

// ----- sim/tb_edge_coverage_bitmap.sv -----
// Self-checking testbench for the edge coverage recorder: directed and random command items.
`timescale 1ns / 100ps

module tb_edge_coverage_bitmap;
   import ecb_pkg::*;

   localparam int MAP_BITS    = 16;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 200_000;

   logic clock;
   logic reset;

   ecb_req_if req_ch();
   ecb_rsp_if rsp_ch();

   edge_coverage_bitmap #(.MAP_BITS(MAP_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [7:0]          hit_count [1 << MAP_BITS];
   logic [MAP_BITS-1:0] prev_loc;
   rsp_type             pending_results [$];
   logic [15:0]         recent_keys [$];
   logic [31:0]         pc_pool [8];

   logic back_to_back = 1'b0;
   logic hold_rsp     = 1'b0;
   int   errors       = 0;
   int   idle_cycles  = 0;
   int   n_branch     = 0;
   int   n_wrap       = 0;
   int   n_plain      = 0;
   int   n_read       = 0;
   int   n_start      = 0;
   int   n_unused     = 0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic bit is_branch_hdr(input logic [HDR_W-1:0] hdr);
      return hdr == HDR_BRANCH || hdr == HDR_CALL_COND || hdr == HDR_CALL_ABS;
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type             res;
      logic [31:0]         scr;
      logic [MAP_BITS-1:0] key;
      res = '0;
      case (cmd_type'(r.cmd))
         CMD_STEP: begin
            if (is_branch_hdr(r.instr[HDR_LSB +: HDR_W])) begin
               scr            = (r.pc << 3) ^ (r.pc >> 3);
               key            = scr[MAP_BITS-1:0] ^ prev_loc;
               hit_count[key] = hit_count[key] + 8'd1;
               prev_loc       = scr[MAP_BITS:1];
               res.count      = hit_count[key];
               res.map_key    = 16'(key);
               res.traced     = 1'b1;
               n_branch++;
               if (res.count == 8'd0) n_wrap++;
               recent_keys.push_back(16'(key));
               if (recent_keys.size() > 16) void'(recent_keys.pop_front());
            end else begin
               n_plain++;
            end
         end
         CMD_READ: begin
            key            = r.index[MAP_BITS-1:0];
            res.count      = hit_count[key];
            res.map_key    = 16'(key);
            hit_count[key] = 8'd0;
            n_read++;
         end
         CMD_START: begin
            prev_loc     = '0;
            hit_count[0] = 8'd1;
            res.count    = 8'd1;
            n_start++;
         end
         default: begin
            n_unused++;
         end
      endcase
      return res;
   endfunction

   function automatic req_type mk_cmd(input cmd_type c, input logic [HDR_W-1:0] hdr,
                                      input logic [53:0] instr, input logic [31:0] pc,
                                      input logic [15:0] index);
      req_type r;
      r.cmd                     = c;
      r.instr                   = instr;
      r.instr[HDR_LSB +: HDR_W] = hdr;
      r.pc                      = pc;
      r.index                   = index;
      return r;
   endfunction

   function automatic logic [53:0] rand_instr();
      return 54'({$urandom(), $urandom()});
   endfunction

   function automatic req_type make_random_cmd();
      req_type          r;
      int               pick;
      logic [HDR_W-1:0] hdr;
      r.instr = rand_instr();
      r.pc    = ($urandom_range(0, 1) == 0) ? pc_pool[$urandom_range(0, 7)] : $urandom();
      if (recent_keys.size() != 0 && $urandom_range(0, 99) < 60)
         r.index = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else
         r.index = 16'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         r.cmd = CMD_STEP;
         case ($urandom_range(0, 2))
            0: hdr = HDR_BRANCH;
            1: hdr = HDR_CALL_COND;
            default: hdr = HDR_CALL_ABS;
         endcase
         r.instr[HDR_LSB +: HDR_W] = hdr;
      end else if (pick < 72) begin
         r.cmd = CMD_STEP;
         do hdr = HDR_W'($urandom()); while (is_branch_hdr(hdr));
         r.instr[HDR_LSB +: HDR_W] = hdr;
      end else if (pick < 88) begin
         r.cmd = CMD_READ;
      end else if (pick < 94) begin
         r.cmd = CMD_START;
      end else begin
         r.cmd = CMD_NONE;
      end
      return r;
   endfunction

   task automatic send_cmd(input req_type r);
      @(negedge clock);
      while (!back_to_back && $urandom_range(0, 99) < 26) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data  = r;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(predict_result(r));
   endtask

   task automatic flag_result(input string what, input rsp_type want, input rsp_type got);
      errors++;
      if (errors <= 10)
         $display("%0t %s: expected count=%0d key=%h traced=%0b, got count=%0d key=%h traced=%0b",
                  $realtime, what, want.count, want.map_key, want.traced,
                  got.count, got.map_key, got.traced);
   endtask

   // receiver: random ready, long hold on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (back_to_back) begin
            rsp_ch.ready = 1'b1;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= 26);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = rsp_ch.data;
         if (pending_results.size() == 0) begin
            flag_result("unexpected result", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.count !== want.count || got.map_key !== want.map_key ||
                got.traced !== want.traced)
               flag_result("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_cmd(mk_cmd(CMD_READ, '0, '0, '0, 16'h0000));
      send_cmd(mk_cmd(CMD_READ, '1, '1, '1, 16'hffff));
      send_cmd(mk_cmd(CMD_STEP, '0, '0, '1, '0));
      send_cmd(mk_cmd(CMD_STEP, '1, '1, '1, '1));
      send_cmd(mk_cmd(CMD_STEP, HDR_CALL_COND | HDR_CALL_ABS, '1, '1, '1));
      send_cmd(mk_cmd(CMD_STEP, HDR_BRANCH, '0, '0, '0));
      send_cmd(mk_cmd(CMD_STEP, HDR_CALL_COND, '1, '1, '1));
      send_cmd(mk_cmd(CMD_STEP, HDR_CALL_ABS, rand_instr(), 32'h8000_0001, '0));
      send_cmd(mk_cmd(CMD_STEP, HDR_BRANCH, rand_instr(), 32'h8000_0001, '0));
      send_cmd(mk_cmd(CMD_STEP, HDR_BRANCH, rand_instr(), 32'h8000_0001, '0));
      send_cmd(mk_cmd(CMD_READ, '0, '0, '0, recent_keys[$]));
      send_cmd(mk_cmd(CMD_READ, '0, '1, '1, recent_keys[$]));
      send_cmd(mk_cmd(CMD_START, '1, '1, '1, '1));
      send_cmd(mk_cmd(CMD_READ, '0, '0, '0, 16'h0000));
      send_cmd(mk_cmd(CMD_NONE, '1, '1, '1, '1));
      send_cmd(mk_cmd(CMD_NONE, '0, '0, '0, '0));
      send_cmd(mk_cmd(CMD_STEP, HDR_CALL_ABS, '1, 32'hffff_fff8, '1));
      repeat (3) send_cmd(mk_cmd(CMD_STEP, HDR_W'($urandom_range(0, 23)), rand_instr(),
                                 $urandom(), 16'($urandom())));
      send_cmd(mk_cmd(CMD_START, '0, '0, '0, '0));
      send_cmd(mk_cmd(CMD_READ, '0, rand_instr(), $urandom(), 16'hffff));
   endtask

   // pc 0 scrambles to 0, so every branch after a run start lands on entry 0
   task automatic test_counter_wrap();
      send_cmd(mk_cmd(CMD_START, '0, rand_instr(), $urandom(), 16'($urandom())));
      repeat (256) send_cmd(mk_cmd(CMD_STEP, HDR_CALL_ABS, rand_instr(), '0, 16'($urandom())));
      send_cmd(mk_cmd(CMD_READ, '0, rand_instr(), $urandom(), 16'h0000));
   endtask

   task automatic test_back_pressure();
      hold_rsp = 1'b1;
      repeat (12) send_cmd(make_random_cmd());
   endtask

   task automatic test_back_to_back();
      back_to_back = 1'b1;
      repeat (100) send_cmd(make_random_cmd());
      back_to_back = 1'b0;
   endtask

   task automatic test_random(input int n_items);
      repeat (n_items) send_cmd(make_random_cmd());
   endtask

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      prev_loc     = '0;
      foreach (hit_count[i]) hit_count[i] = 8'd0;
      foreach (pc_pool[i]) pc_pool[i] = $urandom();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_counter_wrap();
      test_back_pressure();
      test_back_to_back();
      test_random(1060);

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d branch steps (%0d counter wraps), %0d plain steps, %0d reads,",
               n_branch, n_wrap, n_plain, n_read);
      $display("%0d run starts and %0d unused commands; %0d mismatches",
               n_start, n_unused, errors);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
